// ----- src/yad_pkg.sv -----
// ----------------------------------------------------------------------------
// yad_pkg: shared definitions for the anchor decode and score filter
// Field widths, register indexes, reset values and the types that travel
// between the tracker and the scaling stage.
// ----------------------------------------------------------------------------
package yad_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_CLASSES_DEF = 256;
    localparam int VALUE_WIDTH_DEF = 24;

    // Fixed point format of the stream values.
    localparam int FRAC_BITS = 12;

    // Result field widths.
    localparam int BOX_WIDTH   = 12;
    localparam int CLASS_WIDTH = 8;
    localparam int SCORE_WIDTH = 24;

    // Anchor layout: four box values, then objectness, then the class scores.
    localparam int BOX_FIELDS      = 4;
    localparam int OBJ_POS         = 4;
    localparam int FIRST_CLASS_POS = 5;

    // Configuration port.
    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH  = 13;
    localparam int COUNT_WIDTH     = 9;
    localparam int THRESH_WIDTH    = 13;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLASS_COUNT     = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCORE_THRESHOLD = 4'd1;

    localparam logic [COUNT_WIDTH-1:0]  CLASS_COUNT_RST = 9'd80;
    localparam logic [THRESH_WIDTH-1:0] THRESHOLD_RST   = 13'd1638;

    typedef logic signed [BOX_WIDTH-1:0] t_box_val;

    typedef struct packed {
        t_box_val x;
        t_box_val y;
        t_box_val w;
        t_box_val h;
    } t_box;

    typedef struct packed {
        logic                   kept;
        logic                   frame_end;
        logic [CLASS_WIDTH-1:0] class_index;
    } t_res_ctrl;

endpackage

// ----- src/yad_if.sv -----
// ----------------------------------------------------------------------------
// yad_if: channel interfaces of the anchor decode and score filter
// Stream input, result output and configuration write channels, each with
// valid, ready and its payload.
// ----------------------------------------------------------------------------
interface yad_in_if
    import yad_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] raw_value;
    logic                          frame_last;

    modport source (output valid, raw_value, frame_last, input ready);
    modport sink   (input valid, raw_value, frame_last, output ready);
endinterface

interface yad_out_if
    import yad_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic                          kept;
    logic signed [BOX_WIDTH-1:0]   box_x;
    logic signed [BOX_WIDTH-1:0]   box_y;
    logic signed [BOX_WIDTH-1:0]   box_w;
    logic signed [BOX_WIDTH-1:0]   box_h;
    logic [CLASS_WIDTH-1:0]        class_index;
    logic signed [SCORE_WIDTH-1:0] score;
    logic                          frame_end;

    modport source (
        output valid, kept, box_x, box_y, box_w, box_h, class_index, score, frame_end,
        input  ready
    );
    modport sink (
        input  valid, kept, box_x, box_y, box_w, box_h, class_index, score, frame_end,
        output ready
    );
endinterface

interface yad_cfg_if
    import yad_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/yad_tracker.sv -----
// ----------------------------------------------------------------------------
// yad_tracker: anchor position, value capture and running argmax
// Follows the position inside each anchor, stores the box and objectness
// values, keeps the first maximal class score and decides at the anchor's
// end whether a result is due. Due results wait in a single stage register.
// ----------------------------------------------------------------------------
module yad_tracker
    import yad_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [COUNT_WIDTH-1:0]        i_class_count,
    input  logic [THRESH_WIDTH-1:0]       i_threshold,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_raw_value,
    input  logic                          i_frame_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output t_res_ctrl                     o_ctrl,
    output t_box                          o_box,
    output logic signed [VALUE_WIDTH-1:0] o_obj,
    output logic signed [VALUE_WIDTH-1:0] o_best
);

    localparam int PW = $clog2(MAX_CLASSES + FIRST_CLASS_POS);

    localparam logic [PW-1:0] POS_OBJ = PW'(OBJ_POS);
    localparam logic [PW-1:0] POS_CLS = PW'(FIRST_CLASS_POS);

    localparam logic signed [VALUE_WIDTH:0] BOX_HI = (VALUE_WIDTH+1)'(2**(BOX_WIDTH-1) - 1);
    localparam logic signed [VALUE_WIDTH:0] BOX_LO = -BOX_HI - (VALUE_WIDTH+1)'(1);
    localparam logic [VALUE_WIDTH:0]        RND    = (VALUE_WIDTH+1)'(2**FRAC_BITS - 1);

    // Whole pixels: divide by the fraction scale toward zero, then saturate.
    function automatic t_box_val f_box(input logic signed [VALUE_WIDTH-1:0] v);
        logic signed [VALUE_WIDTH:0] adj;
        logic signed [VALUE_WIDTH:0] q;
        adj = $signed({v[VALUE_WIDTH-1], v} + (v[VALUE_WIDTH-1] ? RND : '0));
        q   = adj >>> FRAC_BITS;
        if (q > BOX_HI) begin
            return BOX_WIDTH'(BOX_HI);
        end else if (q < BOX_LO) begin
            return BOX_WIDTH'(BOX_LO);
        end else begin
            return BOX_WIDTH'(q);
        end
    endfunction

    logic [PW-1:0]                 r_pos;
    logic signed [VALUE_WIDTH-1:0] r_box [BOX_FIELDS];
    logic signed [VALUE_WIDTH-1:0] r_obj;
    logic signed [VALUE_WIDTH-1:0] r_best;
    logic [CLASS_WIDTH-1:0]        r_best_class;

    logic                          r_v1;
    t_res_ctrl                     r_ctrl;
    t_box                          r_box_out;
    logic signed [VALUE_WIDTH-1:0] r_obj_out;
    logic signed [VALUE_WIDTH-1:0] r_best_out;

    logic [PW-1:0]                 w_n_eff;
    logic [PW-1:0]                 w_last_pos;
    logic                          w_acc;
    logic                          w_anchor_end;
    logic                          w_keep;
    logic signed [VALUE_WIDTH-1:0] w_thr;
    logic signed [VALUE_WIDTH-1:0] n_best;
    logic [CLASS_WIDTH-1:0]        n_best_class;
    logic [PW-1:0]                 n_pos;

    // Effective class count and the position of the anchor's last value.
    always_comb begin
        if (i_class_count == '0) begin
            w_n_eff = PW'(1);
        end else if (int'(i_class_count) > MAX_CLASSES) begin
            w_n_eff = PW'(MAX_CLASSES);
        end else begin
            w_n_eff = PW'(i_class_count);
        end
        w_last_pos = w_n_eff + POS_OBJ;
    end

    assign o_ready = !r_v1 || i_ready;
    assign w_acc   = i_valid && o_ready;
    assign w_thr   = $signed(VALUE_WIDTH'(i_threshold));

    // Running argmax; the first maximal score wins ties.
    always_comb begin
        n_best       = r_best;
        n_best_class = r_best_class;
        if (r_pos == POS_CLS) begin
            n_best       = i_raw_value;
            n_best_class = '0;
        end else if (r_pos > POS_CLS && i_raw_value > r_best) begin
            n_best       = i_raw_value;
            n_best_class = CLASS_WIDTH'(r_pos - POS_CLS);
        end
    end

    assign w_anchor_end = r_pos >= w_last_pos;
    assign w_keep       = w_anchor_end && (n_best >= w_thr);
    assign n_pos        = (w_anchor_end || i_frame_last) ? '0 : r_pos + PW'(1);

    // Anchor state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_best_class <= '0;
        end else if (w_acc) begin
            r_pos        <= n_pos;
            r_best_class <= n_best_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            if (r_pos < POS_OBJ) begin
                r_box[r_pos[1:0]] <= i_raw_value;
            end
            if (r_pos == POS_OBJ) begin
                r_obj <= i_raw_value;
            end
            r_best <= n_best;
        end
    end

    // Result stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_ready) begin
            r_v1 <= w_acc && (w_keep || i_frame_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ctrl.kept        <= w_keep;
            r_ctrl.frame_end   <= i_frame_last;
            r_ctrl.class_index <= w_keep ? n_best_class : '0;
            r_box_out.x        <= f_box(r_box[0]);
            r_box_out.y        <= f_box(r_box[1]);
            r_box_out.w        <= f_box(r_box[2]);
            r_box_out.h        <= f_box(r_box[3]);
            r_obj_out          <= r_obj;
            r_best_out         <= n_best;
        end
    end

    assign o_valid = r_v1;
    assign o_ctrl  = r_ctrl;
    assign o_box   = r_box_out;
    assign o_obj   = r_obj_out;
    assign o_best  = r_best_out;

endmodule

// ----- src/yad_scale.sv -----
// ----------------------------------------------------------------------------
// yad_scale: score product and output register
// Multiplies objectness by the best class score in one stage, then reduces
// the product to Q12.12 with truncation toward zero and saturation in the
// output register. Box, class and score read as zero when no box is kept.
// ----------------------------------------------------------------------------
module yad_scale
    import yad_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  t_res_ctrl                     i_ctrl,
    input  t_box                          i_box,
    input  logic signed [VALUE_WIDTH-1:0] i_obj,
    input  logic signed [VALUE_WIDTH-1:0] i_best,
    yad_out_if.source                     o_out
);

    localparam int PRW = 2 * VALUE_WIDTH;

    localparam logic signed [PRW-1:0] SC_HI = PRW'(2**(SCORE_WIDTH-1) - 1);
    localparam logic signed [PRW-1:0] SC_LO = -SC_HI - PRW'(1);
    localparam logic [PRW-1:0]        RND   = PRW'(2**FRAC_BITS - 1);

    logic                  r_v2;
    t_res_ctrl             r_ctrl2;
    t_box                  r_box2;
    logic signed [PRW-1:0] r_prod;

    logic                          r_v3;
    logic                          r_kept;
    t_box_val                      r_bx;
    t_box_val                      r_by;
    t_box_val                      r_bw;
    t_box_val                      r_bh;
    logic [CLASS_WIDTH-1:0]        r_cls;
    logic signed [SCORE_WIDTH-1:0] r_score;
    logic                          r_fend;

    logic                          w_adv3;
    logic signed [PRW-1:0]         w_adj;
    logic signed [PRW-1:0]         w_q;
    logic signed [SCORE_WIDTH-1:0] w_score;

    assign w_adv3  = !r_v3 || o_out.ready;
    assign o_ready = !r_v2 || w_adv3;

    // Product stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (o_ready) begin
            r_v2 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctrl2 <= i_ctrl;
            r_box2  <= i_box;
            r_prod  <= i_obj * i_best;
        end
    end

    // Reduce the product to Q12.12, toward zero, with saturation.
    always_comb begin
        w_adj = $signed(r_prod + (r_prod[PRW-1] ? RND : '0));
        w_q   = w_adj >>> FRAC_BITS;
        if (w_q > SC_HI) begin
            w_score = SCORE_WIDTH'(SC_HI);
        end else if (w_q < SC_LO) begin
            w_score = SCORE_WIDTH'(SC_LO);
        end else begin
            w_score = SCORE_WIDTH'(w_q);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_adv3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3 && r_v2) begin
            r_kept  <= r_ctrl2.kept;
            r_fend  <= r_ctrl2.frame_end;
            r_cls   <= r_ctrl2.class_index;
            r_bx    <= r_ctrl2.kept ? r_box2.x : '0;
            r_by    <= r_ctrl2.kept ? r_box2.y : '0;
            r_bw    <= r_ctrl2.kept ? r_box2.w : '0;
            r_bh    <= r_ctrl2.kept ? r_box2.h : '0;
            r_score <= r_ctrl2.kept ? w_score : '0;
        end
    end

    assign o_out.valid       = r_v3;
    assign o_out.kept        = r_kept;
    assign o_out.box_x       = r_bx;
    assign o_out.box_y       = r_by;
    assign o_out.box_w       = r_bw;
    assign o_out.box_h       = r_bh;
    assign o_out.class_index = r_cls;
    assign o_out.score       = r_score;
    assign o_out.frame_end   = r_fend;

endmodule

// ----- src/yolov5_anchor_decode_filter.sv -----
// ----------------------------------------------------------------------------
// yolov5_anchor_decode_filter: detector output decode and score filter
// Turns the detector's value stream into thresholded boxes with their class
// and score, plus one marker result at each frame end.
// ----------------------------------------------------------------------------
// Usage.
// i_in carries one signed Q12.12 value per beat with frame_last on the last
// value of a frame. Each anchor is x, y, w, h, objectness and then
// class_count class scores. o_out carries at most one result per input beat:
// a kept box when the anchor's best class score reaches score_threshold, and
// always a result with frame_end set for the frame's last beat (kept is then
// zero unless that beat also closed a passing anchor).
// i_cfg writes class_count (index 0) and score_threshold (index 1); it is
// always ready, and writes belong to idle periods between frames.
// Throughput is one input beat per cycle while o_out keeps taking results. A
// result reaches o_out through the tracker's result register, the multiplier
// stage and the output register.
// When o_out stalls, results collect in these three registers; once all three
// hold one, i_in stops taking beats until o_out moves again.
// Reset is synchronous and active low; it clears the anchor position and the
// pipeline, and loads class_count with 80 and score_threshold with 1638.
// ----------------------------------------------------------------------------
module yolov5_anchor_decode_filter
    import yad_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    yad_cfg_if.sink   i_cfg,
    yad_in_if.sink    i_in,
    yad_out_if.source o_out
);

    logic [COUNT_WIDTH-1:0]  r_class_count;
    logic [THRESH_WIDTH-1:0] r_score_threshold;

    logic                          w_t_valid;
    logic                          w_s_ready;
    t_res_ctrl                     w_ctrl;
    t_box                          w_box;
    logic signed [VALUE_WIDTH-1:0] w_obj;
    logic signed [VALUE_WIDTH-1:0] w_best;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_count     <= CLASS_COUNT_RST;
            r_score_threshold <= THRESHOLD_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_CLASS_COUNT) begin
                r_class_count <= i_cfg.data[COUNT_WIDTH-1:0];
            end
            if (i_cfg.index == REG_SCORE_THRESHOLD) begin
                r_score_threshold <= i_cfg.data[THRESH_WIDTH-1:0];
            end
        end
    end

    // Anchor tracking and decision.
    yad_tracker #(
        .MAX_CLASSES (MAX_CLASSES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_class_count (r_class_count),
        .i_threshold   (r_score_threshold),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_raw_value   (i_in.raw_value),
        .i_frame_last  (i_in.frame_last),
        .o_valid       (w_t_valid),
        .i_ready       (w_s_ready),
        .o_ctrl        (w_ctrl),
        .o_box         (w_box),
        .o_obj         (w_obj),
        .o_best        (w_best)
    );

    // Score product and output register.
    yad_scale #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_t_valid),
        .o_ready (w_s_ready),
        .i_ctrl  (w_ctrl),
        .i_box   (w_box),
        .i_obj   (w_obj),
        .i_best  (w_best),
        .o_out   (o_out)
    );

endmodule
